>>> rtl/fas_pkg.sv
package fas_pkg;

   localparam int unsigned MANT_W = 25;
   localparam int unsigned LZC_W  = 5;

   typedef struct packed {
      logic             sign_a;
      logic             sign_b;
      logic [7:0]       exp_big;
      logic [MANT_W-1:0] mant_a;
      logic [MANT_W-1:0] mant_b;
   } align_type;

   typedef struct packed {
      logic             sign;
      logic [7:0]       exp_big;
      logic [MANT_W:0]  mag;
   } sum_type;

   typedef struct packed {
      logic [31:0] sum_bits;
      logic        underflow;
      logic        overflow;
   } result_type;

   function automatic logic [LZC_W-1:0] lead_zeros(input logic [MANT_W-2:0] v);
      logic [LZC_W-1:0] n;
      logic             found;
      n = '0;
      found = 1'b0;
      for (int i = MANT_W - 2; i >= 0; i--) begin
         if (!found && v[i]) begin
            found = 1'b1;
            n = LZC_W'(MANT_W - 2 - i);
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/float32_add_sub_truncating.sv
// Throughput: one transaction per cycle; three register stages (align,
// add/subtract, normalize) advance together whenever the output is free.
// Reset: synchronous, active high; clears the stage valid bits only.
module float32_add_sub_truncating (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [0] opcode, [32:1] operand_a, [64:33] operand_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] sum_bits, [32] underflow, [33] overflow
);

   logic [2:0] valid_ff, valid_in;
   logic       advance;
   fas_pkg::align_type  align_ff;
   fas_pkg::sum_type    sum_ff;
   fas_pkg::result_type result_ff;

   // The whole pipe moves as one when the last stage is empty or drained.
   assign advance    = !valid_ff[2] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[2];
   assign rsp_tdata  = {6'd0, result_ff.overflow, result_ff.underflow, result_ff.sum_bits};

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   fas_align u_align (
      .clock     (clock),
      .enable    (advance),
      .opcode    (req_tdata[0]),
      .operand_a (req_tdata[32:1]),
      .operand_b (req_tdata[64:33]),
      .align_ff  (align_ff)
   );

   fas_addsub u_addsub (
      .clock    (clock),
      .enable   (advance),
      .align_ff (align_ff),
      .sum_ff   (sum_ff)
   );

   fas_norm u_norm (
      .clock     (clock),
      .enable    (advance),
      .sum_ff    (sum_ff),
      .result_ff (result_ff)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(result_ff.underflow && result_ff.overflow))
      else $error("both flags set");
   a_uf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.underflow |-> result_ff.sum_bits == 32'd0)
      else $error("underflow without zero result");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted transaction lost");

endmodule

>>> rtl/fas_align.sv
module fas_align (
   input  logic                clock,
   input  logic                enable,
   input  logic                opcode,
   input  logic [31:0]         operand_a,
   input  logic [31:0]         operand_b,
   output fas_pkg::align_type  align_ff
);

   logic [7:0]  ea, eb;
   logic [23:0] ha, hb;
   logic [24:0] ma, mb;
   logic [8:0]  dab, dba;
   fas_pkg::align_type align_in;

   always_comb begin
      ea = (operand_a[30:23] != 8'd0) ? operand_a[30:23] : 8'd1;
      eb = (operand_b[30:23] != 8'd0) ? operand_b[30:23] : 8'd1;
      ha = {operand_a[30:23] != 8'd0, operand_a[22:0]};
      hb = {operand_b[30:23] != 8'd0, operand_b[22:0]};
      ma = {ha, 1'b0};
      mb = {hb, 1'b0};
      dab = {1'b0, ea} - {1'b0, eb};
      dba = {1'b0, eb} - {1'b0, ea};
      align_in.sign_a = operand_a[31];
      align_in.sign_b = operand_b[31] ^ opcode;
      if (ea > eb) begin
         align_in.exp_big = ea;
         align_in.mant_a  = ma;
         align_in.mant_b  = (dab[7:5] != 3'd0) ? '0 : (mb >> dab[4:0]);
      end else begin
         align_in.exp_big = eb;
         align_in.mant_b  = mb;
         align_in.mant_a  = (dba[7:5] != 3'd0) ? '0 : (ma >> dba[4:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         align_ff <= align_in;
      end
   end

endmodule

>>> rtl/fas_addsub.sv
module fas_addsub (
   input  logic                clock,
   input  logic                enable,
   input  fas_pkg::align_type  align_ff,
   output fas_pkg::sum_type    sum_ff
);

   fas_pkg::sum_type sum_in;

   always_comb begin
      sum_in.exp_big = align_ff.exp_big;
      if (align_ff.sign_a == align_ff.sign_b) begin
         sum_in.sign = align_ff.sign_a;
         sum_in.mag  = {1'b0, align_ff.mant_a} + {1'b0, align_ff.mant_b};
      end else if (align_ff.mant_a > align_ff.mant_b) begin
         sum_in.sign = align_ff.sign_a;
         sum_in.mag  = {1'b0, align_ff.mant_a - align_ff.mant_b};
      end else begin
         sum_in.sign = align_ff.sign_b;
         sum_in.mag  = {1'b0, align_ff.mant_b - align_ff.mant_a};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

endmodule

>>> rtl/fas_norm.sv
module fas_norm (
   input  logic                clock,
   input  logic                enable,
   input  fas_pkg::sum_type    sum_ff,
   output fas_pkg::result_type result_ff
);

   // The magnitude holds at most 26 bits; the stored exponent is one above
   // the true one because of the extra low bit, which the shift amounts absorb.
   logic [4:0]  lz;
   logic [9:0]  exp_n;
   logic [25:0] m_n;
   fas_pkg::result_type result_in;

   always_comb begin
      lz = fas_pkg::lead_zeros(sum_ff.mag[23:0]);
      m_n = '0;
      exp_n = '0;
      if (sum_ff.mag[25]) begin
         m_n = sum_ff.mag >> 2;
         exp_n = {2'b00, sum_ff.exp_big} + 10'd1;
      end else if (sum_ff.mag[24]) begin
         m_n = sum_ff.mag >> 1;
         exp_n = {2'b00, sum_ff.exp_big};
      end else begin
         m_n = sum_ff.mag << lz;
         exp_n = {2'b00, sum_ff.exp_big} - 10'd1 - {5'd0, lz};
      end
      result_in.sum_bits  = '0;
      result_in.underflow = 1'b0;
      result_in.overflow  = 1'b0;
      if (sum_ff.mag == '0) begin
         result_in.sum_bits = '0;
      end else if (exp_n[9] || exp_n == 10'd0) begin
         result_in.underflow = 1'b1;
      end else if (exp_n >= 10'd255) begin
         result_in.sum_bits = {sum_ff.sign, 8'hFF, 23'd0};
         result_in.overflow = 1'b1;
      end else begin
         result_in.sum_bits = {sum_ff.sign, exp_n[7:0], m_n[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

endmodule

>>> bench/float32_add_sub_truncating_test.sv
module float32_add_sub_truncating_test;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   typedef struct packed {
      logic [31:0] sum_bits;
      logic        underflow;
      logic        overflow;
   } sum_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // [0] opcode, [32:1] operand_a, [64:33] operand_b
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] sum_bits, [32] underflow, [33] overflow

   sum_result_type expected_sums[$];
   int          error_count;
   int          sums_checked;
   int          items_sent;
   bit          stall_enable;

   float32_add_sub_truncating DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Truncating single-precision add/subtract, computed on bit vectors.
   function automatic sum_result_type predict_sum(logic op, logic [31:0] a, logic [31:0] b);
      sum_result_type r;
      logic        sa, sb, sign;
      int          ea, eb, e, d;
      logic [31:0] ma, mb, m;
      r = '0;
      sa = a[31];
      sb = b[31] ^ op;
      ea = a[30:23];
      eb = b[30:23];
      ma = {9'b0, a[22:0]};
      mb = {9'b0, b[22:0]};
      if (ea != 0) ma[23] = 1'b1; else ea = 1;
      if (eb != 0) mb[23] = 1'b1; else eb = 1;
      ma = ma << 1;
      mb = mb << 1;
      ea = ea - 1;
      eb = eb - 1;
      if (ea > eb) begin
         d = ea - eb;
         mb = (d >= 32) ? 32'd0 : mb >> d;
         e = ea;
      end else begin
         d = eb - ea;
         ma = (d >= 32) ? 32'd0 : ma >> d;
         e = eb;
      end
      if (sa == sb) begin
         sign = sa;
         m = ma + mb;
      end else if (ma > mb) begin
         sign = sa;
         m = ma - mb;
      end else begin
         sign = sb;
         m = mb - ma;
      end
      if (m == 0) return r;
      while (m >= 32'h100_0000) begin
         m = m >> 1;
         e++;
      end
      while (m < 32'h80_0000) begin
         m = m << 1;
         e--;
      end
      if (e <= 0) begin
         r.underflow = 1'b1;
      end else if (e >= 255) begin
         r.sum_bits = {sign, 31'h7F80_0000};
         r.overflow = 1'b1;
      end else begin
         r.sum_bits = {sign, e[7:0], m[22:0]};
      end
      return r;
   endfunction

   // The valid line stays high between transactions that follow with no gap;
   // it drops only before an idle stretch or in wait_for_drain.
   task automatic send_operation(logic op, logic [31:0] a, logic [31:0] b);
      int gap;
      gap = $urandom_range(0, 9);
      if (stall_enable && gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {7'b0, b, a, op};
      req_tvalid <= 1'b1;
      expected_sums.push_back(predict_sum(op, a, b));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_sums.size() != 0) @(negedge clock);
   endtask

   // Response side: random backpressure while stalls are enabled; checks every accepted transaction.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else begin
            stall = stall_enable ? $urandom_range(0, 9) : 0;
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            do @(posedge clock); while (!rsp_tvalid);
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               error_count++;
            end else begin
               sum_result_type want;
               sum_result_type got;
               want = expected_sums.pop_front();
               got = {rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[33]};
               if (got.sum_bits !== want.sum_bits) begin
                  $display("%0t: sum_bits expected %h actual %h", $time,
                           want.sum_bits, got.sum_bits);
                  error_count++;
               end
               if (got.underflow !== want.underflow) begin
                  $display("%0t: underflow expected %b actual %b", $time,
                           want.underflow, got.underflow);
                  error_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %b actual %b", $time,
                           want.overflow, got.overflow);
                  error_count++;
               end
               sums_checked++;
            end
         end
      end
   end

   task automatic test_directed_cases();
      send_operation(OP_ADD, 32'h3F80_0000, 32'h3F80_0000);   // 1 + 1
      send_operation(OP_SUB, 32'h3F80_0000, 32'h3F80_0000);   // exact cancellation
      send_operation(OP_ADD, 32'hBF80_0000, 32'h3F80_0000);
      send_operation(OP_ADD, 32'h0000_0000, 32'h0000_0000);
      send_operation(OP_SUB, 32'h8000_0000, 32'h0000_0000);
      send_operation(OP_ADD, 32'h0000_0001, 32'h0000_0001);   // subnormals
      send_operation(OP_ADD, 32'h007F_FFFF, 32'h0000_0001);
      send_operation(OP_SUB, 32'h0080_0000, 32'h0000_0001);   // drops below normal range
      send_operation(OP_SUB, 32'h0080_0001, 32'h0080_0000);
      send_operation(OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow
      send_operation(OP_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF);
      send_operation(OP_ADD, 32'h7F80_0000, 32'h3F80_0000);   // infinity as a number
      send_operation(OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);   // NaN patterns
      send_operation(OP_ADD, 32'h4F80_0000, 32'h0000_0001);   // huge alignment shift
      send_operation(OP_SUB, 32'h3F80_0000, 32'h3380_0000);
      send_operation(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operation(OP_SUB, 32'h4000_0000, 32'h3FFF_FFFF);   // heavy normalization
      send_operation(OP_ADD, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
      send_operation(OP_SUB, 32'h0000_0000, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_operations(int count);
      logic [31:0] a, b;
      int          sel;
      for (int i = 0; i < count; i++) begin
         a = $urandom();
         b = $urandom();
         sel = $urandom_range(0, 5);
         // Near exponents and near magnitudes stress cancellation and carry.
         if (sel == 1) b[30:23] = 8'(a[30:23] + $urandom_range(0, 3) - 1);
         if (sel == 2) b = a ^ $urandom_range(0, 255);
         if (sel == 3) a[30:23] = $urandom_range(0, 2) == 0 ? 8'h00 : 8'hFF;
         if (sel == 4) b[30:23] = $urandom_range(0, 1) ? 8'hFE : 8'h01;
         send_operation(1'($urandom_range(0, 1)), a, b);
         if (i == count / 2) wait_for_drain();
      end
   endtask

   task automatic test_back_to_back(int count);
      stall_enable = 1'b0;
      test_random_operations(count);
      wait_for_drain();
      stall_enable = 1'b1;
   endtask

   initial begin
      error_count = 0;
      sums_checked = 0;
      items_sent = 0;
      stall_enable = 1'b1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_for_drain();
      test_random_operations(1000);
      test_back_to_back(400);
      wait_for_drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d add/subtract operations, checked %0d results,", items_sent,
               sums_checked);
      $display("covering subnormal, overflow, cancellation and stalled-stream cases.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
